### design/rtyd_pkg.sv
// package with payload types, coefficients and dither table for the rgb to yuv quantiser
`timescale 1ns / 1ps
`default_nettype none
package rtyd_pkg;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 8;

    localparam logic [CfgIndexWidth-1:0] CFG_LUMA_FIVE_BIT  = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_ORDERED_DITHER = 2'd1;

    localparam logic [23:0] LUMA_R_COEF = 24'd19595;
    localparam logic [23:0] LUMA_G_COEF = 24'd38470;
    localparam logic [23:0] LUMA_B_COEF = 24'd7471;
    localparam logic [23:0] U_R_COEF    = 24'd22117;
    localparam logic [23:0] U_G_COEF    = 24'd43419;
    localparam logic [23:0] V_G_COEF    = 24'd54878;
    localparam logic [23:0] V_B_COEF    = 24'd10658;
    localparam logic [23:0] HALF_STEP   = 24'h800000;
    localparam int          DITHER_SHIFT = 20;
    localparam logic signed [13:0] CHROMA_HALF = 14'sd128;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] col_phase;
        logic [1:0] row_phase;
    } pixel_t;

    typedef struct packed {
        logic [5:0] luma;
        logic [4:0] chroma_u;
        logic [4:0] chroma_v;
    } result_t;

    typedef struct packed {
        logic luma_five_bit;
        logic ordered_dither;
    } cfg_t;

    typedef struct packed {
        logic [23:0] fixed_y;
        logic [23:0] threshold;
        logic        five_bit;
        logic [7:0]  u_base;
        logic [7:0]  v_base;
        logic [7:0]  red;
        logic [7:0]  blue;
    } prod_t;

    typedef struct packed {
        logic [29:0]        luma_acc;
        logic signed [12:0] u_scaled;
        logic signed [12:0] v_scaled;
    } scale_t;

    function automatic logic [3:0] bayer(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] val;
        case ({row, col})
            4'h0: val = 4'd0;
            4'h1: val = 4'd8;
            4'h2: val = 4'd2;
            4'h3: val = 4'd10;
            4'h4: val = 4'd12;
            4'h5: val = 4'd4;
            4'h6: val = 4'd14;
            4'h7: val = 4'd6;
            4'h8: val = 4'd3;
            4'h9: val = 4'd11;
            4'ha: val = 4'd1;
            4'hb: val = 4'd9;
            4'hc: val = 4'd15;
            4'hd: val = 4'd7;
            4'he: val = 4'd13;
            4'hf: val = 4'd5;
            default: val = 4'd0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

### design/rtyd_cfg.sv
// configuration register file for luma width and dither mode
`timescale 1ns / 1ps
`default_nettype none
module rtyd_cfg
    import rtyd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LUMA_FIVE_BIT:  cfg_next.luma_five_bit  = cfg_data[0];
                CFG_ORDERED_DITHER: cfg_next.ordered_dither = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

### design/rtyd_mult.sv
// first stage: weighted luma sum, partial chroma bases and threshold
`timescale 1ns / 1ps
`default_nettype none
module rtyd_mult
    import rtyd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   up_valid,
    output logic        up_ready,
    input  wire pixel_t up_data,
    output logic        dn_valid,
    input  wire logic   dn_ready,
    output prod_t       dn_data
);

    logic  valid_reg;
    logic  valid_next;
    prod_t data_reg;
    prod_t data_next;

    logic [23:0] r24;
    logic [23:0] g24;
    logic [23:0] b24;
    logic [23:0] u_prod;
    logic [23:0] v_prod;

    assign r24 = {16'd0, up_data.red};
    assign g24 = {16'd0, up_data.green};
    assign b24 = {16'd0, up_data.blue};

    assign u_prod = r24 * U_R_COEF + g24 * U_G_COEF;
    assign v_prod = g24 * V_G_COEF + b24 * V_B_COEF;

    always_comb
    begin
        data_next.fixed_y   = r24 * LUMA_R_COEF + g24 * LUMA_G_COEF + b24 * LUMA_B_COEF;
        data_next.threshold = cfg.ordered_dither
                            ? {bayer(up_data.row_phase, up_data.col_phase), 20'd0}
                            : HALF_STEP;
        data_next.five_bit  = cfg.luma_five_bit;
        data_next.u_base    = u_prod[23:16];
        data_next.v_base    = v_prod[23:16];
        data_next.red       = up_data.red;
        data_next.blue      = up_data.blue;
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;
    assign dn_valid   = valid_reg;
    assign dn_data    = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

### design/rtyd_scale.sv
// second stage: luma scaling with threshold, chroma difference halved and scaled by 31
`timescale 1ns / 1ps
`default_nettype none
module rtyd_scale
    import rtyd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   up_valid,
    output logic        up_ready,
    input  wire prod_t  up_data,
    output logic        dn_valid,
    input  wire logic   dn_ready,
    output scale_t      dn_data
);

    logic   valid_reg;
    logic   valid_next;
    scale_t data_reg;
    scale_t data_next;

    logic [29:0]        y30;
    logic [29:0]        y_scaled;
    logic signed [8:0]  u_diff;
    logic signed [8:0]  v_diff;
    logic signed [12:0] u_half;
    logic signed [12:0] v_half;

    assign y30      = {6'd0, up_data.fixed_y};
    assign y_scaled = up_data.five_bit ? ((y30 << 5) - y30) : ((y30 << 6) - y30);

    assign u_diff = $signed({1'b0, up_data.blue}) - $signed({1'b0, up_data.u_base});
    assign v_diff = $signed({1'b0, up_data.red})  - $signed({1'b0, up_data.v_base});

    // floor halving
    assign u_half = {{5{u_diff[8]}}, u_diff[8:1]};
    assign v_half = {{5{v_diff[8]}}, v_diff[8:1]};

    always_comb
    begin
        data_next.luma_acc = y_scaled + {6'd0, up_data.threshold};
        data_next.u_scaled = (u_half <<< 5) - u_half;
        data_next.v_scaled = (v_half <<< 5) - v_half;
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;
    assign dn_valid   = valid_reg;
    assign dn_data    = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

### design/rtyd_round.sv
// third stage: luma truncation and sign-dependent chroma rounding into the output register
`timescale 1ns / 1ps
`default_nettype none
module rtyd_round
    import rtyd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   up_valid,
    output logic        up_ready,
    input  wire scale_t up_data,
    output logic        dn_valid,
    input  wire logic   dn_ready,
    output result_t     dn_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    logic signed [13:0] u_wide;
    logic signed [13:0] v_wide;
    logic signed [13:0] u_round;
    logic signed [13:0] v_round;

    assign u_wide  = {up_data.u_scaled[12], up_data.u_scaled};
    assign v_wide  = {up_data.v_scaled[12], up_data.v_scaled};
    assign u_round = u_wide[13] ? (u_wide - CHROMA_HALF) : (u_wide + CHROMA_HALF);
    assign v_round = v_wide[13] ? (v_wide - CHROMA_HALF) : (v_wide + CHROMA_HALF);

    always_comb
    begin
        data_next.luma     = up_data.luma_acc[29:24];
        data_next.chroma_u = u_round[12:8];
        data_next.chroma_v = v_round[12:8];
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;
    assign dn_valid   = valid_reg;
    assign dn_data    = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

### design/rgb_to_yuv_dither_quantiser.sv
// top level: rgb to yuv conversion with bayer 4x4 dithered luma quantisation
// a pixel passes the multiply, scale and round registers before result valid
// throughput: one pixel per cycle unless stalled; three stages: multiply, scale, round
// each stage holds its transaction under backpressure and refills when the next one drains
// reset clears the stage valid bits and both configuration registers to zero
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_yuv_dither_quantiser
    import rtyd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     pixel_valid,
    output logic                          pixel_ready,
    input  wire pixel_t                   pixel,
    output logic                          result_valid,
    input  wire logic                     result_ready,
    output result_t                       result,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data
);

    cfg_t   cfg;
    logic   prod_valid;
    logic   prod_ready;
    prod_t  prod;
    logic   scale_valid;
    logic   scale_ready;
    scale_t scale;

    rtyd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtyd_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (pixel_valid),
        .up_ready (pixel_ready),
        .up_data  (pixel),
        .dn_valid (prod_valid),
        .dn_ready (prod_ready),
        .dn_data  (prod)
    );

    rtyd_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prod_valid),
        .up_ready (prod_ready),
        .up_data  (prod),
        .dn_valid (scale_valid),
        .dn_ready (scale_ready),
        .dn_data  (scale)
    );

    rtyd_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (scale_valid),
        .up_ready (scale_ready),
        .up_data  (scale),
        .dn_valid (result_valid),
        .dn_ready (result_ready),
        .dn_data  (result)
    );

endmodule
`default_nettype wire
